// File: rtl/assert_macros.svh
// Assertion macros for the RTL modules, included by sccb_seq.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, suspended while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen on a rising edge of clk outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: rtl/sccb_pkg.sv
// Types, codes and helper functions for the SCCB register access master.
package sccb_pkg;

  // Request selector codes.
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;
  localparam logic [1:0] REQ_NOP   = 2'd3;

  // Reset value of the attempt limit.
  localparam logic [3:0] MAX_ATTEMPTS_RESET = 4'd5;

  // Sequencer phases.
  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_START1  = 5'd1,
    PH_DEV1    = 5'd2,
    PH_ACKDEV1 = 5'd3,
    PH_REG     = 5'd4,
    PH_ACKREG  = 5'd5,
    PH_DATA    = 5'd6,
    PH_ACKDATA = 5'd7,
    PH_STOP1   = 5'd8,
    PH_START2  = 5'd9,
    PH_DEV2    = 5'd10,
    PH_ACKDEV2 = 5'd11,
    PH_GET     = 5'd12,
    PH_NACK    = 5'd13,
    PH_STOP2   = 5'd14,
    PH_END     = 5'd31
  } phase_t;

  // One input transaction.
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] device_addr;
    logic [7:0] sub_addr;
    logic [7:0] write_data;
    logic       sda_sample;
  } req_item_t;

  // One result transaction.
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_enable;
    logic       busy_res;
    logic       request_ignored;
    logic       done_res;
    logic [1:0] nack_count;
    logic [7:0] read_data;
  } res_item_t;

  // Phases that shift a whole byte (sixteen half periods).
  function automatic logic is_byte_phase(phase_t p);
    return (p == PH_DEV1) || (p == PH_REG) || (p == PH_DATA) ||
           (p == PH_DEV2) || (p == PH_GET);
  endfunction

  // Phases that sample an acknowledge.
  function automatic logic is_ack_phase(phase_t p);
    return (p == PH_ACKDEV1) || (p == PH_ACKREG) || (p == PH_ACKDATA) ||
           (p == PH_ACKDEV2);
  endfunction

  // Phase that follows p once p has run its length.
  function automatic phase_t next_phase(phase_t p, logic rd);
    phase_t np;
    np = PH_END;
    unique case (p)
      PH_IDLE:    np = PH_START1;
      PH_START1:  np = PH_DEV1;
      PH_DEV1:    np = PH_ACKDEV1;
      PH_ACKDEV1: np = PH_REG;
      PH_REG:     np = PH_ACKREG;
      PH_ACKREG:  np = rd ? PH_STOP1 : PH_DATA;
      PH_DATA:    np = PH_ACKDATA;
      PH_ACKDATA: np = PH_STOP1;
      PH_STOP1:   np = rd ? PH_START2 : PH_END;
      PH_START2:  np = PH_DEV2;
      PH_DEV2:    np = PH_ACKDEV2;
      PH_ACKDEV2: np = PH_GET;
      PH_GET:     np = PH_NACK;
      PH_NACK:    np = PH_STOP2;
      default:    np = PH_END;
    endcase
    return np;
  endfunction

endpackage

// File: rtl/sccb_ifs.sv
// Valid/ready channel interfaces for request and result transactions.
interface sccb_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] device_addr;
  logic [7:0] sub_addr;
  logic [7:0] write_data;
  logic       sda_sample;

  modport source (output valid, req_type, device_addr, sub_addr, write_data, sda_sample,
                  input ready);
  modport sink (input valid, req_type, device_addr, sub_addr, write_data, sda_sample,
                output ready);
endinterface

interface sccb_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_enable;
  logic       busy_res;
  logic       request_ignored;
  logic       done_res;
  logic [1:0] nack_count;
  logic [7:0] read_data;

  modport source (output valid, scl_level, sda_level, sda_enable, busy_res,
                  request_ignored, done_res, nack_count, read_data,
                  input ready);
  modport sink (input valid, scl_level, sda_level, sda_enable, busy_res,
                request_ignored, done_res, nack_count, read_data,
                output ready);
endinterface

// File: rtl/sccb_in_reg.sv
// Input register stage: captures one request transaction and holds it until taken.
module sccb_in_reg (
  input  logic               clk,
  input  logic               rst,
  sccb_req_if.sink           req_ch,
  input  logic               take,
  output logic               held_valid,
  output sccb_pkg::req_item_t held_item
);

  // The stage may refill in the same cycle that its content moves on.
  assign req_ch.ready = !held_valid || take;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (req_ch.ready) begin
      held_valid <= req_ch.valid;
    end
  end

  // Payload, loaded on every accepted transaction.
  always_ff @(posedge clk) begin
    if (req_ch.valid && req_ch.ready) begin
      held_item.req_type    <= req_ch.req_type;
      held_item.device_addr <= req_ch.device_addr;
      held_item.sub_addr    <= req_ch.sub_addr;
      held_item.write_data  <= req_ch.write_data;
      held_item.sda_sample  <= req_ch.sda_sample;
    end
  end

endmodule

// File: rtl/sccb_seq.sv
// Bus sequencer: state registers and the single step taken for each request.
`include "assert_macros.svh"

module sccb_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  sccb_pkg::req_item_t item,
  input  logic [3:0]          max_attempts,
  output sccb_pkg::res_item_t result
);

  // Sequencer state.
  sccb_pkg::phase_t phase, phase_next;
  logic [3:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [1:0] error_tally, error_tally_next;
  logic [3:0] attempt_count, attempt_count_next;
  logic [7:0] latched_device, latched_device_next;
  logic [7:0] latched_register, latched_register_next;
  logic [7:0] latched_value, latched_value_next;
  logic       is_read, is_read_next;
  logic [7:0] received_byte, received_byte_next;
  logic       clock_out, clock_out_next;
  logic       data_out, data_out_next;
  logic       data_drive, data_drive_next;

  // Per-step flags.
  logic       set_levels;
  logic       ignored;
  logic       done;
  logic [1:0] nacks;
  logic [7:0] rdata;

  // Helpers of the tick step.
  logic [4:0]       bit_inc;
  logic             phase_over;
  sccb_pkg::phase_t np;
  logic [1:0]       err_upd;
  logic [7:0]       recv_upd;

  // Next-state logic.
  always_comb begin
    phase_next            = phase;
    bit_index_next        = bit_index;
    shift_byte_next       = shift_byte;
    error_tally_next      = error_tally;
    attempt_count_next    = attempt_count;
    latched_device_next   = latched_device;
    latched_register_next = latched_register;
    latched_value_next    = latched_value;
    is_read_next          = is_read;
    received_byte_next    = received_byte;
    set_levels            = 1'b0;
    ignored               = 1'b0;
    done                  = 1'b0;
    nacks                 = 2'd0;
    rdata                 = 8'd0;
    bit_inc               = {1'b0, bit_index} + 5'd1;
    phase_over            = sccb_pkg::is_byte_phase(phase) ? bit_inc[4] : (bit_inc >= 5'd2);
    np                    = sccb_pkg::next_phase(phase, is_read);
    err_upd               = error_tally;
    recv_upd              = received_byte;

    priority if ((item.req_type == sccb_pkg::REQ_WRITE) ||
                 (item.req_type == sccb_pkg::REQ_READ)) begin
      if (phase != sccb_pkg::PH_IDLE) begin
        ignored = 1'b1;
      end else begin
        is_read_next          = (item.req_type == sccb_pkg::REQ_READ);
        latched_device_next   = item.device_addr;
        latched_register_next = item.sub_addr;
        latched_value_next    = item.write_data;
        attempt_count_next    = 4'd0;
        error_tally_next      = 2'd0;
        received_byte_next    = 8'd0;
        phase_next            = sccb_pkg::PH_START1;
        bit_index_next        = 4'd0;
        set_levels            = 1'b1;
      end
    end else if ((item.req_type == sccb_pkg::REQ_TICK) &&
                 (phase != sccb_pkg::PH_IDLE)) begin
      // Acknowledge sample on the high half, saturating at three.
      if (sccb_pkg::is_ack_phase(phase) && (bit_index == 4'd1) && item.sda_sample &&
          (error_tally != 2'd3)) begin
        err_upd = error_tally + 2'd1;
      end
      // Read bit sampled at the end of each high half.
      if ((phase == sccb_pkg::PH_GET) && bit_index[0]) begin
        recv_upd = {received_byte[6:0], item.sda_sample};
      end
      // Transmit shift after each high half.
      if ((phase != sccb_pkg::PH_GET) && sccb_pkg::is_byte_phase(phase) && bit_index[0]) begin
        shift_byte_next = {shift_byte[6:0], 1'b0};
      end
      error_tally_next   = err_upd;
      received_byte_next = recv_upd;
      bit_index_next     = bit_inc[3:0];
      if (phase_over) begin
        bit_index_next = 4'd0;
        if (np == sccb_pkg::PH_END) begin
          if ((err_upd != 2'd0) &&
              (({1'b0, attempt_count} + 5'd1) < {1'b0, max_attempts})) begin
            // Failed attempt: start over.
            attempt_count_next = attempt_count + 4'd1;
            error_tally_next   = 2'd0;
            received_byte_next = 8'd0;
            phase_next         = sccb_pkg::PH_START1;
          end else begin
            done       = 1'b1;
            nacks      = err_upd;
            rdata      = recv_upd;
            phase_next = sccb_pkg::PH_IDLE;
          end
        end else begin
          phase_next = np;
          unique case (np)
            sccb_pkg::PH_DEV1: shift_byte_next = latched_device;
            sccb_pkg::PH_REG:  shift_byte_next = latched_register;
            sccb_pkg::PH_DATA: shift_byte_next = latched_value;
            sccb_pkg::PH_DEV2: shift_byte_next = latched_device + 8'd1;
            default: ;
          endcase
        end
      end
      set_levels = 1'b1;
    end else begin
      // Tick while idle or no-operation selector: state is kept.
      set_levels = 1'b0;
    end
  end

  // Output logic: line levels for the coming delay and the result fields.
  always_comb begin
    clock_out_next  = clock_out;
    data_out_next   = data_out;
    data_drive_next = data_drive;
    if (set_levels) begin
      unique case (phase_next)
        sccb_pkg::PH_START1, sccb_pkg::PH_START2: begin
          clock_out_next  = 1'b1;
          data_out_next   = !bit_index_next[0];
          data_drive_next = 1'b1;
        end
        sccb_pkg::PH_DEV1, sccb_pkg::PH_REG, sccb_pkg::PH_DATA, sccb_pkg::PH_DEV2: begin
          clock_out_next  = bit_index_next[0];
          data_out_next   = shift_byte_next[7];
          data_drive_next = 1'b1;
        end
        sccb_pkg::PH_ACKDEV1, sccb_pkg::PH_ACKREG, sccb_pkg::PH_ACKDATA,
        sccb_pkg::PH_ACKDEV2, sccb_pkg::PH_GET: begin
          clock_out_next  = bit_index_next[0];
          data_drive_next = 1'b0;
        end
        sccb_pkg::PH_STOP1, sccb_pkg::PH_STOP2: begin
          clock_out_next  = bit_index_next[0];
          data_out_next   = 1'b0;
          data_drive_next = 1'b1;
        end
        sccb_pkg::PH_NACK: begin
          clock_out_next  = bit_index_next[0];
          data_out_next   = 1'b1;
          data_drive_next = 1'b1;
        end
        default: begin
          clock_out_next  = 1'b1;
          data_out_next   = 1'b1;
          data_drive_next = 1'b1;
        end
      endcase
    end
    result.scl_level       = clock_out_next;
    result.sda_level       = data_out_next;
    result.sda_enable      = data_drive_next;
    result.busy_res        = (phase_next != sccb_pkg::PH_IDLE);
    result.request_ignored = ignored;
    result.done_res        = done;
    result.nack_count      = nacks;
    result.read_data       = rdata;
  end

  // State registers, advanced once per step.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= sccb_pkg::PH_IDLE;
      bit_index        <= 4'd0;
      shift_byte       <= 8'd0;
      error_tally      <= 2'd0;
      attempt_count    <= 4'd0;
      latched_device   <= 8'd0;
      latched_register <= 8'd0;
      latched_value    <= 8'd0;
      is_read          <= 1'b0;
      received_byte    <= 8'd0;
      clock_out        <= 1'b1;
      data_out         <= 1'b1;
      data_drive       <= 1'b1;
    end else if (step) begin
      phase            <= phase_next;
      bit_index        <= bit_index_next;
      shift_byte       <= shift_byte_next;
      error_tally      <= error_tally_next;
      attempt_count    <= attempt_count_next;
      latched_device   <= latched_device_next;
      latched_register <= latched_register_next;
      latched_value    <= latched_value_next;
      is_read          <= is_read_next;
      received_byte    <= received_byte_next;
      clock_out        <= clock_out_next;
      data_out         <= data_out_next;
      data_drive       <= data_drive_next;
    end
  end

  // A finished transfer leaves the sequencer idle.
  `ASSERT_CLK(a_done_idle, step && done |=> phase == sccb_pkg::PH_IDLE,
              "done step did not return the sequencer to idle")
  // A dropped request leaves the transfer where it was.
  `ASSERT_CLK(a_ignored_hold, step && ignored |=> $stable(phase) && $stable(bit_index),
              "dropped request disturbed the sequencer")
  // The idle sequencer always sits at the start of its bit count with lines high.
  `ASSERT_CLK(a_idle_levels, phase == sccb_pkg::PH_IDLE |->
              bit_index == 4'd0 && clock_out && data_out && data_drive,
              "idle sequencer not at rest")
  // Status fields are zero outside a done step.
  `ASSERT_NEVER(a_status_zero, !done && (nacks != 2'd0 || rdata != 8'd0),
                "status fields set without done")

endmodule

// File: rtl/sccb_master_register_access.sv
// SCCB register access master: one sequencer step per request transaction.
// Each request transaction (write request, read request, delay tick, or no-op) produces
// exactly one result transaction. A transaction passes through an input register and
// the sequencer step into a result register, from which its result is offered. A new
// request is accepted every cycle while results are taken; the single sequencer step
// between those registers sets that rate. The attempt limit is written through
// cfg_we/cfg_wdata; the user must write it only while no transfer is in flight, as the
// block itself does not enforce this.
module sccb_master_register_access (
  input  logic       clk,
  input  logic       rst,
  sccb_req_if.sink   req_ch,
  sccb_res_if.source res_ch,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata
);

  logic                held_valid;
  sccb_pkg::req_item_t held_item;
  logic                take;
  sccb_pkg::res_item_t step_res;
  sccb_pkg::res_item_t res_reg;
  logic                res_valid;
  logic [3:0]          max_attempts;

  // Attempt limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_attempts <= sccb_pkg::MAX_ATTEMPTS_RESET;
    end else if (cfg_we) begin
      max_attempts <= cfg_wdata;
    end
  end

  // The held request moves on whenever the result register is free or being emptied.
  assign take = held_valid && (!res_valid || res_ch.ready);

  sccb_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .req_ch     (req_ch),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  sccb_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .step         (take),
    .item         (held_item),
    .max_attempts (max_attempts),
    .result       (step_res)
  );

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || res_ch.ready) begin
      res_valid <= held_valid;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (take) begin
      res_reg <= step_res;
    end
  end

  // Result channel.
  assign res_ch.valid           = res_valid;
  assign res_ch.scl_level       = res_reg.scl_level;
  assign res_ch.sda_level       = res_reg.sda_level;
  assign res_ch.sda_enable      = res_reg.sda_enable;
  assign res_ch.busy_res        = res_reg.busy_res;
  assign res_ch.request_ignored = res_reg.request_ignored;
  assign res_ch.done_res        = res_reg.done_res;
  assign res_ch.nack_count      = res_reg.nack_count;
  assign res_ch.read_data       = res_reg.read_data;

endmodule
